// File: rtl/core/ffe_pkg.sv
// Shared constants, codes, decay function and palette function for the fire effect frame engine.
`default_nettype none

package ffe_pkg;

  // Default edge length of the square heat map.
  localparam int SIDE_DEF = 128;

  // Widths of the request and response payload fields.
  localparam int OPCODE_W = 2;
  localparam int COORD_W  = 7;
  localparam int OFFSET_W = 7;
  localparam int HEAT_W   = 8;
  localparam int COLOR_W  = 16;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_SEED = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RUN  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

  // Response kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PASS  = 1'b1;

  // Color packing formats.
  localparam logic FMT_565 = 1'b0;
  localparam logic FMT_555 = 1'b1;

  // Seeding: base heat and the largest offset that is honored.
  localparam logic [HEAT_W-1:0]   SEED_BASE    = 8'd127;
  localparam logic [OFFSET_W-1:0] SEED_OFF_MAX = 7'd126;

  // Decay thresholds and amounts.
  localparam logic [HEAT_W-1:0] DECAY_HI_LIM = 8'd128;
  localparam logic [HEAT_W-1:0] DECAY_HI     = 8'd3;
  localparam logic [HEAT_W-1:0] DECAY_LO_LIM = 8'd5;
  localparam logic [HEAT_W-1:0] DECAY_LO     = 8'd5;

  // Palette ramp boundaries: black to red, red to yellow, yellow to white.
  localparam logic [HEAT_W-1:0] PAL_RED_END = 8'd85;
  localparam logic [HEAT_W-1:0] PAL_YEL_END = 8'd170;
  localparam logic [HEAT_W-1:0] PAL_FULL    = 8'd255;

  // Cooling applied to one averaged heat value.
  function automatic logic [HEAT_W-1:0] decay(input logic [HEAT_W-1:0] v);
    logic [HEAT_W-1:0] res;
    if (v > DECAY_HI_LIM) begin
      res = v - DECAY_HI;
    end else if (v > DECAY_LO_LIM) begin
      res = v - DECAY_LO;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // Fire palette. Each ramp is 85 steps of 255/85 = 3 exactly, so the
  // channel ramp is three times the step number.
  function automatic logic [COLOR_W-1:0] fire_color(input logic [HEAT_W-1:0] idx,
                                                    input logic fmt);
    logic [HEAT_W-1:0] step;
    logic [HEAT_W-1:0] s;
    logic [HEAT_W-1:0] r;
    logic [HEAT_W-1:0] g;
    logic [HEAT_W-1:0] b;
    logic [COLOR_W-1:0] res;
    if (idx <= PAL_RED_END) begin
      step = idx - 8'd1;
    end else if (idx <= PAL_YEL_END) begin
      step = idx - (PAL_RED_END + 8'd1);
    end else begin
      step = idx - (PAL_YEL_END + 8'd1);
    end
    s = HEAT_W'({1'b0, step, 1'b0} + {2'b00, step});
    if (idx == '0) begin
      r = '0;
      g = '0;
      b = '0;
    end else if (idx <= PAL_RED_END) begin
      r = s;
      g = '0;
      b = '0;
    end else if (idx <= PAL_YEL_END) begin
      r = PAL_FULL;
      g = s;
      b = '0;
    end else begin
      r = PAL_FULL;
      g = PAL_FULL;
      b = s;
    end
    if (fmt == FMT_555) begin
      res = {1'b0, r[7:3], g[7:3], b[7:3]};
    end else begin
      res = {r[7:3], g[7:2], b[7:3]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ffe_if.sv
// Request and response channel interfaces of the fire effect frame engine.
`default_nettype none

interface ffe_req_if import ffe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [COORD_W-1:0]  column;
  logic [COORD_W-1:0]  row;
  logic [OFFSET_W-1:0] seed_offset;

  modport source (output valid, output opcode, output column, output row,
                  output seed_offset, input ready);
  modport sink (input valid, input opcode, input column, input row,
                input seed_offset, output ready);
endinterface

interface ffe_rsp_if import ffe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [HEAT_W-1:0]  pixel_index;
  logic [COLOR_W-1:0] color;

  modport source (output valid, output kind, output pixel_index, output color,
                  input ready);
  modport sink (input valid, input kind, input pixel_index, input color,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/fire_effect_frame_engine.sv
// Fire effect frame engine: heat map memory, pass sequencer and palette output.
// Pixel read: the map is read as the request is accepted, then the output register
// loads the response, one request at a time. Seed: four writes into one column, no response.
// Fire pass: every 2x2 cell goes through the single write port of the heat map.
// Reset: synchronous; a clearing sweep zeroes every map cell before the first request
// is taken. color_format resets to 0.
`default_nettype none

module fire_effect_frame_engine import ffe_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  ffe_req_if.sink    req,
  ffe_rsp_if.source  rsp
);

  localparam int DEPTH = SIDE * SIDE;
  localparam int MW    = $clog2(DEPTH);
  localparam int RW    = $clog2(SIDE);

  // Sequencer states.
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SEED  = 7'b0000100,
    S_PRE   = 7'b0001000,
    S_CELL  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration register.
  logic color_format;

  // Heat map memory.
  logic [HEAT_W-1:0] heat [DEPTH];
  logic [HEAT_W-1:0] rdata;
  logic              mem_re;
  logic [MW-1:0]     mem_raddr;
  logic              mem_we;
  logic [MW-1:0]     mem_waddr;
  logic [HEAT_W-1:0] mem_wdata;

  // Clearing sweep and seeding.
  logic [MW-1:0]     clr_addr;
  logic [1:0]        seed_cnt;
  logic [RW-1:0]     seed_col;
  logic [HEAT_W-1:0] seed_val;
  logic              seed_ok;
  logic              clear_we;
  logic              seed_we;

  // Pass loop counters and window registers.
  logic [1:0]        ph;
  logic [RW-1:0]     cur_r;
  logic [RW-1:0]     cur_c;
  logic [HEAT_W-1:0] win_l;
  logic [HEAT_W-1:0] win_c;
  logic [HEAT_W-1:0] win_r;
  logic [9:0]        acc;
  logic [HEAT_W-1:0] d_val;
  logic [HEAT_W:0]   mix_sum;
  logic [HEAT_W-1:0] cell_val;
  logic              last_col;
  logic              last_row;

  // 2x2 write-back unit.
  logic              wr_load;
  logic              wr_busy;
  logic [1:0]        wr_idx;
  logic [MW-1:0]     wr_base;
  logic [HEAT_W-1:0] wr_val;

  // Request and response bookkeeping.
  logic accept;
  logic resp_kind;
  logic rd_ok;
  logic out_load;
  logic in_map;
  logic [OFFSET_W-1:0] off_sat;

  function automatic logic [MW-1:0] cell_addr(input logic [RW-1:0] rr,
                                              input logic [RW-1:0] cc);
    return MW'(MW'(rr) * MW'(SIDE)) + MW'(cc);
  endfunction

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_map    = (32'(req.column) < 32'(SIDE)) && (32'(req.row) < 32'(SIDE));
  assign off_sat   = (req.seed_offset > SEED_OFF_MAX) ? SEED_OFF_MAX : req.seed_offset;
  assign last_col  = (cur_c == RW'(SIDE - 4));
  assign last_row  = (cur_r == RW'(SIDE - 2));
  assign out_load  = (state == S_RESP) && (!rsp.valid || rsp.ready);

  // Configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_format <= FMT_565;
    end else if (cfg_we) begin
      color_format <= cfg_wdata;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == MW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (req.opcode)
            OP_SEED: state_next = S_SEED;
            OP_RUN:  state_next = S_PRE;
            OP_READ: state_next = S_RESP;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SEED: begin
        if (seed_cnt == 2'd3) state_next = S_IDLE;
      end
      S_PRE: begin
        if (ph == 2'd2) state_next = S_CELL;
      end
      S_CELL: begin
        if (ph == 2'd3 && last_col) begin
          state_next = last_row ? S_DRAIN : S_PRE;
        end
      end
      S_DRAIN: begin
        if (!wr_busy) state_next = S_RESP;
      end
      S_RESP: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Counters of the sweep, the seed writes and the pass loops.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      seed_cnt <= '0;
      ph       <= '0;
      cur_r    <= '0;
      cur_c    <= '0;
    end else begin
      if (state == S_CLEAR) clr_addr <= clr_addr + MW'(1);
      if (state == S_SEED) begin
        seed_cnt <= seed_cnt + 2'd1;
      end else begin
        seed_cnt <= '0;
      end
      case (state)
        S_IDLE: begin
          ph    <= '0;
          cur_r <= RW'(4);
          cur_c <= RW'(2);
        end
        S_PRE: begin
          ph <= (ph == 2'd2) ? 2'd0 : ph + 2'd1;
        end
        S_CELL: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            if (last_col) begin
              cur_c <= RW'(2);
              cur_r <= cur_r + RW'(2);
            end else begin
              cur_c <= cur_c + RW'(2);
            end
          end
        end
        default: ph <= '0;
      endcase
    end
  end

  // Seed parameters and the read range check, captured when any request is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      seed_col <= RW'(req.column);
      seed_val <= SEED_BASE + HEAT_W'(off_sat);
      seed_ok  <= (32'(req.column) < 32'(SIDE));
      rd_ok    <= in_map;
    end
  end

  // Response kind follows the operation that leads into the response state.
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_kind <= KIND_PIXEL;
    end else if (accept) begin
      resp_kind <= (req.opcode == OP_RUN) ? KIND_PASS : KIND_PIXEL;
    end
  end

  // Cell datapath: the shared adder builds the neighbor sum, then the up neighbor is
  // mixed in and the result decayed.
  assign d_val    = last_row ? '0 : rdata;
  assign mix_sum  = {1'b0, acc[9:2]} + {1'b0, rdata};
  assign cell_val = decay(mix_sum[HEAT_W:1]);

  always_ff @(posedge clk) begin
    if (state == S_PRE) begin
      if (ph == 2'd1) win_l <= rdata;
      if (ph == 2'd2) win_c <= rdata;
    end
    if (state == S_CELL) begin
      case (ph)
        2'd0: acc <= {2'b00, win_l} + {2'b00, win_c};
        2'd1: begin
          win_r <= rdata;
          acc   <= acc + {2'b00, rdata};
        end
        2'd2: acc <= acc + {2'b00, d_val};
        default: begin
          win_l <= win_c;
          win_c <= win_r;
        end
      endcase
    end
  end

  // Write-back unit: four writes of one cell value into a 2x2 block.
  assign wr_load = (state == S_CELL) && (ph == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_busy <= 1'b0;
      wr_idx  <= '0;
    end else if (wr_load) begin
      wr_busy <= 1'b1;
      wr_idx  <= '0;
    end else if (wr_busy) begin
      wr_idx  <= wr_idx + 2'd1;
      wr_busy <= (wr_idx != 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_load) begin
      wr_base <= cell_addr(cur_r - RW'(4), cur_c);
      wr_val  <= cell_val;
    end
  end

  // Memory write port selection.
  assign clear_we = (state == S_CLEAR);
  assign seed_we  = (state == S_SEED) && seed_ok;
  assign mem_we   = clear_we || seed_we || wr_busy;

  always_comb begin
    if (clear_we) begin
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (seed_we) begin
      mem_waddr = cell_addr(RW'(SIDE - 4) + RW'(seed_cnt), seed_col);
      mem_wdata = seed_val;
    end else begin
      mem_waddr = wr_base + (wr_idx[1] ? MW'(SIDE) : MW'(0)) + MW'(wr_idx[0]);
      mem_wdata = wr_val;
    end
  end

  // Memory read port selection.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cell_addr(cur_r, cur_c);
    case (state)
      S_IDLE: begin
        mem_re    = accept && (req.opcode == OP_READ);
        mem_raddr = cell_addr(RW'(req.row), RW'(req.column));
      end
      S_PRE: begin
        mem_re    = (ph != 2'd2);
        mem_raddr = cell_addr(cur_r, (ph == 2'd0) ? RW'(0) : RW'(2));
      end
      S_CELL: begin
        case (ph)
          2'd0: begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr(cur_r, cur_c + RW'(2));
          end
          2'd1: begin
            mem_re    = !last_row;
            mem_raddr = cell_addr(cur_r + RW'(2), cur_c);
          end
          2'd2: begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr(cur_r - RW'(2), cur_c);
          end
          default: mem_re = 1'b0;
        endcase
      end
      default: mem_re = 1'b0;
    endcase
  end

  // Heat map storage.
  always_ff @(posedge clk) begin
    if (mem_we) heat[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata <= heat[mem_raddr];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.kind <= resp_kind;
      if (resp_kind == KIND_PIXEL && rd_ok) begin
        rsp.pixel_index <= rdata;
        rsp.color       <= fire_color(rdata, color_format);
      end else begin
        rsp.pixel_index <= '0;
        rsp.color       <= '0;
      end
    end
  end

  // The memory write port never has two users at once.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({clear_we, seed_we, wr_busy}))
    else $error("heat map write port has more than one user");

  // A new cell result only arrives as the previous 2x2 write finishes.
  assert property (@(posedge clk) disable iff (rst)
    (wr_load && wr_busy) |-> (wr_idx == 2'd3))
    else $error("cell result overwrote a pending 2x2 write");

  // A pass is reported only after all its writes are in the map.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> !wr_busy)
    else $error("response issued with writes still pending");

  // A pass-done response carries zero payload.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.kind == KIND_PASS) |-> (rsp.pixel_index == '0 && rsp.color == '0))
    else $error("pass-done response carries data");

  // The clearing sweep hands over to idle and nothing else.
  assert property (@(posedge clk) disable iff (rst)
    ($past(state == S_CLEAR) && state != S_CLEAR) |-> (state == S_IDLE))
    else $error("clearing sweep left to a state other than idle");

endmodule

`default_nettype wire
